[hw/rtl/i2p_pkg.sv]
// Package for the infix to postfix converter.
// Holds character codes, result status codes and the operator classifier.
// No dependencies.
package i2p_pkg;

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_NONE  = 8'h00;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNMATCHED = 2'd2;

  typedef logic [7:0] symbol_t;
  typedef logic [1:0] status_t;

  function automatic logic is_operator(input symbol_t sym);
    return sym inside {"+", "-", "*", "/", "<", ">", "!", "~", "@", "#", "$", "%",
                       "^", "&", "("};
  endfunction

endpackage

[hw/rtl/infix_to_postfix_stack.sv]
// Infix to postfix converter, operator stack in a synchronous RAM (registered read).
// A plain character or an overflow result is held pending, then sent out; a push writes
// the RAM; each stack pop on a close parenthesis or at expression end reads the RAM,
// then makes a result. One input symbol in flight; output register decouples out_tready.
// Reset (rst_n low, synchronous) empties the stack and drops any pending word.
// Depends on i2p_pkg.
module infix_to_postfix_stack #(
  parameter int STACK_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] symbol
  input  logic        in_tlast,   // expr_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_symbol, [9:8] status, [15:10] zero
  output logic        out_tuser,  // run_last
  output logic        out_tlast   // expr_done
);
  import i2p_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  localparam logic [2:0] S_IDLE       = 3'd0;
  localparam logic [2:0] S_CLOSE      = 3'd1;
  localparam logic [2:0] S_POP_WAIT   = 3'd2;
  localparam logic [2:0] S_FLUSH      = 3'd3;
  localparam logic [2:0] S_FLUSH_WAIT = 3'd4;
  localparam logic [2:0] S_FIN        = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt, count_dec;
  logic          last_r, last_nxt;
  logic          pend_valid_r, pend_valid_nxt;
  symbol_t       pend_sym_r, pend_sym_nxt;
  status_t       pend_stat_r, pend_stat_nxt;

  logic          out_valid_r;
  symbol_t       out_sym_r;
  status_t       out_stat_r;
  logic          out_run_r, out_done_r;

  logic          out_free, res_ok;
  logic          out_load;
  symbol_t       ld_sym;
  status_t       ld_stat;
  logic          ld_run, ld_done;
  logic          new_res;
  symbol_t       new_sym;
  status_t       new_stat;

  symbol_t       stack_mem [STACK_DEPTH];
  logic          we, re;
  symbol_t       rd_q;

  assign count_dec = count_r - CW'(1);
  assign out_free  = !out_valid_r || out_tready;
  assign res_ok    = !pend_valid_r || out_free;
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    last_nxt       = last_r;
    pend_valid_nxt = pend_valid_r;
    pend_sym_nxt   = pend_sym_r;
    pend_stat_nxt  = pend_stat_r;
    we             = 1'b0;
    re             = 1'b0;
    out_load       = 1'b0;
    ld_sym         = pend_sym_r;
    ld_stat        = pend_stat_r;
    ld_run         = 1'b0;
    ld_done        = 1'b0;
    new_res        = 1'b0;
    new_sym        = rd_q;
    new_stat       = ST_OK;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          last_nxt       = in_tlast;
          pend_valid_nxt = 1'b0;
          if (is_operator(in_tdata)) begin
            if (count_r >= CW'(STACK_DEPTH)) begin
              pend_valid_nxt = 1'b1;
              pend_sym_nxt   = in_tdata;
              pend_stat_nxt  = ST_OVERFLOW;
              state_nxt      = in_tlast ? S_FLUSH : S_FIN;
            end else begin
              we        = 1'b1;
              count_nxt = count_r + CW'(1);
              state_nxt = in_tlast ? S_FLUSH : S_IDLE;
            end
          end else if (in_tdata == CH_CLOSE) begin
            state_nxt = S_CLOSE;
          end else begin
            pend_valid_nxt = 1'b1;
            pend_sym_nxt   = in_tdata;
            pend_stat_nxt  = ST_OK;
            state_nxt      = in_tlast ? S_FLUSH : S_FIN;
          end
        end
      end
      S_CLOSE: begin
        if (count_r == '0) begin
          new_res  = 1'b1;
          new_sym  = CH_CLOSE;
          new_stat = ST_UNMATCHED;
          if (res_ok) begin
            state_nxt = S_FIN;
          end
        end else begin
          re        = 1'b1;
          count_nxt = count_dec;
          state_nxt = S_POP_WAIT;
        end
      end
      S_POP_WAIT: begin
        if (rd_q == CH_OPEN) begin
          state_nxt = last_r ? S_FLUSH : S_FIN;
        end else begin
          new_res = 1'b1;
          if (res_ok) begin
            state_nxt = S_CLOSE;
          end
        end
      end
      S_FLUSH: begin
        if (count_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          re        = 1'b1;
          count_nxt = count_dec;
          state_nxt = S_FLUSH_WAIT;
        end
      end
      S_FLUSH_WAIT: begin
        new_res = 1'b1;
        if (res_ok) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FIN: begin
        if (pend_valid_r) begin
          if (out_free) begin
            out_load       = 1'b1;
            ld_run         = 1'b1;
            ld_done        = last_r;
            pend_valid_nxt = 1'b0;
            state_nxt      = S_IDLE;
          end
        end else if (last_r) begin
          if (out_free) begin
            out_load  = 1'b1;
            ld_sym    = CH_NONE;
            ld_stat   = ST_OK;
            ld_run    = 1'b1;
            ld_done   = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (new_res && res_ok) begin
      if (pend_valid_r) begin
        out_load = 1'b1;
      end
      pend_valid_nxt = 1'b1;
      pend_sym_nxt   = new_sym;
      pend_stat_nxt  = new_stat;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      stack_mem[count_r[AW-1:0]] <= in_tdata;
    end
    if (re) begin
      rd_q <= stack_mem[count_dec[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      pend_valid_r <= pend_valid_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    last_r      <= last_nxt;
    pend_sym_r  <= pend_sym_nxt;
    pend_stat_r <= pend_stat_nxt;
    if (out_load) begin
      out_sym_r  <= ld_sym;
      out_stat_r <= ld_stat;
      out_run_r  <= ld_run;
      out_done_r <= ld_done;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_stat_r, out_sym_r};
  assign out_tuser  = out_run_r;
  assign out_tlast  = out_done_r;

endmodule
